FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge
`define SCPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check that a condition is followed by another in the next cycle
`define SCPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/scpc_pkg.sv
// ----------------------------------------------------------------------------
// scpc_pkg
// Constants and types of the segment cull, project and clip block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpc_pkg;

    localparam int PANEL_WIDTH  = 256;
    localparam int PANEL_HEIGHT = 256;
    localparam int RIGHT        = PANEL_WIDTH * 16;
    localparam int BOTTOM       = PANEL_HEIGHT * 16;
    localparam int OUT_MAX      = 8191;
    localparam int LIM_X        = (RIGHT < OUT_MAX) ? RIGHT : OUT_MAX;
    localparam int LIM_Y        = (BOTTOM < OUT_MAX) ? BOTTOM : OUT_MAX;

    localparam int CW = 24;   // coordinate width
    localparam int DW = 25;   // delta and divider operand width
    localparam int OW = 13;   // panel output width
    localparam int QW = 17;   // quotient width, one divider stage per bit

    typedef enum logic [2:0] {
        REG_CENTER_MODE = 3'd0,
        REG_VIEWER_X    = 3'd1,
        REG_VIEWER_Y    = 3'd2,
        REG_CULL_RADIUS = 3'd3,
        REG_SCALE_X     = 3'd4,
        REG_SCALE_Y     = 3'd5,
        REG_ORIGIN_X    = 3'd6,
        REG_ORIGIN_Y    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic zero;
        logic qneg;
        logic pneg;
        logic sat;
    } flags_t;

    typedef struct packed {
        logic                 keep;
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        flags_t [3:0]         ef;
    } side_t;

endpackage

FILE: rtl/core/scpc_div.sv
// ----------------------------------------------------------------------------
// scpc_div
// Pipelined restoring divider: floor(num * 2^(QW-1) / den), one quotient bit
// per stage. The quotient must be known to fit in QW bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpc_div
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [scpc_pkg::DW-1:0] num,
    input  logic [scpc_pkg::DW-1:0] den,
    output logic [scpc_pkg::QW-1:0] quo
);
    import scpc_pkg::*;

    localparam int RW = DW + QW - 1;

    logic [RW-1:0] rem_in  [QW];
    logic [DW-1:0] den_in  [QW];
    logic [QW-1:0] quo_in  [QW];
    logic [RW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [RW-1:0] dsh;
            logic          take;

            if (k == 0)
            begin : g_first
                assign rem_in[k] = {num, {(QW-1){1'b0}}};
                assign den_in[k] = den;
                assign quo_in[k] = '0;
            end
            else
            begin : g_rest
                assign rem_in[k] = rem_reg[k-1];
                assign den_in[k] = den_reg[k-1];
                assign quo_in[k] = quo_reg[k-1];
            end

            assign dsh  = RW'(den_in[k]) << (QW - 1 - k);
            assign take = (rem_in[k] >= dsh);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_in[k] - dsh) : rem_in[k];
                    den_reg[k] <= den_in[k];
                    quo_reg[k] <= quo_in[k] | (QW'(take) << (QW - 1 - k));
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

FILE: rtl/core/segment_cull_project_clip.sv
// ----------------------------------------------------------------------------
// segment_cull_project_clip
// Culls a world-space segment, projects it to panel space and clips it.
// ----------------------------------------------------------------------------
// Input stream s_*: one segment per word. Output stream m_*: one clipped
// segment per word; culled, rejected or too short segments give no word.
// Configuration: cfg_wen, cfg_index, cfg_data write one register per edge;
// write only while no segment is in flight (the block does not enforce this).
// Throughput: one segment per cycle while s_tready is high.
// Pipeline: 25 register stages from input acceptance to m_tvalid, with the
// first loaded at the accepting edge: 5 stages of cull, projection and edge
// set-up, 17 divider stages (one quotient bit each, four dividers side by
// side), one clip stage, one interpolation multiply stage, then the output
// register.
// Reset: all stages empty, registers at their defaults, s_tready high.
// Stall: the output register holds while m_tready is low; the pipeline keeps
// moving until one more result lands in a skid register, then s_tready
// drops and the whole pipeline holds until the output word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_cull_project_clip
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // clip_start_x, clip_start_y, clip_end_x, clip_end_y, pad
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import scpc_pkg::*;

    // configuration
    logic                 center_mode_reg;
    logic signed [23:0]   viewer_x_reg, viewer_y_reg;
    logic [22:0]          cull_radius_reg;
    logic [15:0]          scale_x_reg, scale_y_reg;
    logic signed [15:0]   origin_x_reg, origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_mode_reg <= 1'b1;
            viewer_x_reg    <= '0;
            viewer_y_reg    <= '0;
            cull_radius_reg <= 23'd7360;
            scale_x_reg     <= 16'd16384;
            scale_y_reg     <= 16'd16384;
            origin_x_reg    <= 16'sd2048;
            origin_y_reg    <= 16'sd2048;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CENTER_MODE: center_mode_reg <= cfg_data[0];
                REG_VIEWER_X:    viewer_x_reg    <= cfg_data;
                REG_VIEWER_Y:    viewer_y_reg    <= cfg_data;
                REG_CULL_RADIUS: cull_radius_reg <= cfg_data[22:0];
                REG_SCALE_X:     scale_x_reg     <= cfg_data[15:0];
                REG_SCALE_Y:     scale_y_reg     <= cfg_data[15:0];
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data[15:0];
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    function automatic logic signed [CW-1:0] project(input logic signed [41:0] prod,
                                                     input logic signed [15:0] org);
        logic signed [41:0] rnd;
        logic signed [28:0] sum;
        rnd = (prod + 42'sd8192) >>> 14;
        sum = $signed(rnd[28:0]) + org;
        if (sum < -29'sd8388608)
            return 24'h800000;
        else if (sum > 29'sd8388607)
            return 24'h7FFFFF;
        else
            return sum[CW-1:0];
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic [OW-1:0] lerp(input logic signed [CW-1:0] a,
                                           input logic signed [42:0] prod,
                                           input logic [OW-1:0]      lim);
        logic signed [42:0] rnd;
        logic signed [28:0] sum;
        rnd = (prod + 43'sd32768) >>> 16;
        sum = $signed(rnd[28:0]) + a;
        if (sum < 0)
            return '0;
        else if (sum > $signed({16'd0, lim}))
            return lim;
        else
            return sum[OW-1:0];
    endfunction

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = !skid_valid_reg;

    // stage 1: cull and offset from reference
    logic signed [CW-1:0] wx0, wy0, wx1, wy1;
    logic signed [DW-1:0] vxp, vxm, vyp, vym, rxe, rye;
    logic                 outside;
    logic                 s1_valid_reg, s1_keep_reg;
    logic signed [DW-1:0] s1_dx0_reg, s1_dy0_reg, s1_dx1_reg, s1_dy1_reg;
    logic signed [DW-1:0] s1_dx0_next, s1_dy0_next, s1_dx1_next, s1_dy1_next;
    logic                 s1_keep_next;

    always_comb
    begin
        wx0 = $signed(s_tdata[23:0]);
        wy0 = $signed(s_tdata[47:24]);
        wx1 = $signed(s_tdata[71:48]);
        wy1 = $signed(s_tdata[95:72]);
        vxp = viewer_x_reg + $signed({2'b00, cull_radius_reg});
        vxm = viewer_x_reg - $signed({2'b00, cull_radius_reg});
        vyp = viewer_y_reg + $signed({2'b00, cull_radius_reg});
        vym = viewer_y_reg - $signed({2'b00, cull_radius_reg});
        outside = (vxp < wx0 && vxp < wx1) || (vxm > wx0 && vxm > wx1) ||
                  (vyp < wy0 && vyp < wy1) || (vym > wy0 && vym > wy1);
        s1_keep_next = !center_mode_reg || !outside;
        rxe = center_mode_reg ? DW'(viewer_x_reg) : '0;
        rye = center_mode_reg ? DW'(viewer_y_reg) : '0;
        s1_dx0_next = wx0 - rxe;
        s1_dy0_next = wy0 - rye;
        s1_dx1_next = wx1 - rxe;
        s1_dy1_next = wy1 - rye;
    end

    // stage 2: scale products
    logic                 s2_valid_reg, s2_keep_reg;
    logic signed [41:0]   s2_px0_reg, s2_py0_reg, s2_px1_reg, s2_py1_reg;
    logic signed [41:0]   s2_px0_next, s2_py0_next, s2_px1_next, s2_py1_next;

    always_comb
    begin
        s2_px0_next = s1_dx0_reg * $signed({1'b0, scale_x_reg});
        s2_py0_next = s1_dy0_reg * $signed({1'b0, scale_y_reg});
        s2_px1_next = s1_dx1_reg * $signed({1'b0, scale_x_reg});
        s2_py1_next = s1_dy1_reg * $signed({1'b0, scale_y_reg});
    end

    // stage 3: round, add origin, saturate
    logic                 s3_valid_reg, s3_keep_reg;
    logic signed [CW-1:0] s3_x0_reg, s3_y0_reg, s3_x1_reg, s3_y1_reg;
    logic signed [CW-1:0] s3_x0_next, s3_y0_next, s3_x1_next, s3_y1_next;

    always_comb
    begin
        s3_x0_next = project(s2_px0_reg, origin_x_reg);
        s3_y0_next = project(s2_py0_reg, origin_y_reg);
        s3_x1_next = project(s2_px1_reg, origin_x_reg);
        s3_y1_next = project(s2_py1_reg, origin_y_reg);
    end

    // stage 4: deltas and far-edge distances
    logic                 s4_valid_reg, s4_keep_reg;
    logic signed [CW-1:0] s4_x0_reg, s4_y0_reg;
    logic signed [DW-1:0] s4_dx_reg, s4_dy_reg, s4_qr_reg, s4_qb_reg;
    logic signed [DW-1:0] s4_dx_next, s4_dy_next, s4_qr_next, s4_qb_next;

    always_comb
    begin
        s4_dx_next = s3_x1_reg - s3_x0_reg;
        s4_dy_next = s3_y1_reg - s3_y0_reg;
        s4_qr_next = $signed(DW'(RIGHT)) - s3_x0_reg;
        s4_qb_next = $signed(DW'(BOTTOM)) - s3_y0_reg;
    end

    // stage 5: divider operands and edge flags
    logic                 s5_valid_reg;
    side_t                s5_side_reg, s5_side_next;
    logic [DW-1:0]        s5_num_reg [4];
    logic [DW-1:0]        s5_den_reg [4];
    logic [DW-1:0]        s5_num_next [4];
    logic [DW-1:0]        s5_den_next [4];
    logic signed [DW-1:0] eq [4];
    logic                 dxz, dyz;

    always_comb
    begin
        dxz   = (s4_dx_reg == '0);
        dyz   = (s4_dy_reg == '0);
        eq[0] = DW'(s4_x0_reg);
        eq[1] = s4_qr_reg;
        eq[2] = DW'(s4_y0_reg);
        eq[3] = s4_qb_reg;
        s5_den_next[0] = mag(s4_dx_reg);
        s5_den_next[1] = mag(s4_dx_reg);
        s5_den_next[2] = mag(s4_dy_reg);
        s5_den_next[3] = mag(s4_dy_reg);
        s5_side_next.keep = s4_keep_reg;
        s5_side_next.x0   = s4_x0_reg;
        s5_side_next.y0   = s4_y0_reg;
        s5_side_next.dx   = s4_dx_reg;
        s5_side_next.dy   = s4_dy_reg;
        s5_side_next.ef[0].zero = dxz;
        s5_side_next.ef[1].zero = dxz;
        s5_side_next.ef[2].zero = dyz;
        s5_side_next.ef[3].zero = dyz;
        s5_side_next.ef[0].pneg = !s4_dx_reg[DW-1] && !dxz;
        s5_side_next.ef[1].pneg = s4_dx_reg[DW-1];
        s5_side_next.ef[2].pneg = !s4_dy_reg[DW-1] && !dyz;
        s5_side_next.ef[3].pneg = s4_dy_reg[DW-1];
        for (int i = 0; i < 4; i++)
        begin
            s5_num_next[i]          = mag(eq[i]);
            s5_side_next.ef[i].qneg = eq[i][DW-1];
            s5_side_next.ef[i].sat  = ({1'b0, s5_num_next[i]} >= {s5_den_next[i], 1'b0});
        end
    end

    // pipeline registers of stages 1 to 5
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_keep_reg <= s1_keep_next;
            s1_dx0_reg  <= s1_dx0_next;
            s1_dy0_reg  <= s1_dy0_next;
            s1_dx1_reg  <= s1_dx1_next;
            s1_dy1_reg  <= s1_dy1_next;
            s2_keep_reg <= s1_keep_reg;
            s2_px0_reg  <= s2_px0_next;
            s2_py0_reg  <= s2_py0_next;
            s2_px1_reg  <= s2_px1_next;
            s2_py1_reg  <= s2_py1_next;
            s3_keep_reg <= s2_keep_reg;
            s3_x0_reg   <= s3_x0_next;
            s3_y0_reg   <= s3_y0_next;
            s3_x1_reg   <= s3_x1_next;
            s3_y1_reg   <= s3_y1_next;
            s4_keep_reg <= s3_keep_reg;
            s4_x0_reg   <= s3_x0_reg;
            s4_y0_reg   <= s3_y0_reg;
            s4_dx_reg   <= s4_dx_next;
            s4_dy_reg   <= s4_dy_next;
            s4_qr_reg   <= s4_qr_next;
            s4_qb_reg   <= s4_qb_next;
            s5_side_reg <= s5_side_next;
            for (int i = 0; i < 4; i++)
            begin
                s5_num_reg[i] <= s5_num_next[i];
                s5_den_reg[i] <= s5_den_next[i];
            end
        end
    end

    // divider stages, side data travels alongside
    logic [QW-1:0] quo [4];
    logic          dv_reg [QW];
    side_t         sb_reg [QW];

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_div
            scpc_div u_div
            (
                .clk (clk),
                .en  (en),
                .num (s5_num_reg[g]),
                .den (s5_den_reg[g]),
                .quo (quo[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= s5_valid_reg;
            for (int k = 1; k < QW; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= s5_side_reg;
            for (int k = 1; k < QW; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // clip stage: combine the left, right, top and bottom limits
    side_t                sd;
    logic signed [18:0]   r, t0, t1;
    logic [QW-1:0]        qm;
    logic                 st_keep_next;
    logic [QW-1:0]        st_t0_next, st_t1_next;
    logic                 st_valid_reg, st_keep_reg;
    logic [QW-1:0]        st_t0_reg, st_t1_reg;
    logic signed [CW-1:0] st_x0_reg, st_y0_reg;
    logic signed [DW-1:0] st_dx_reg, st_dy_reg;

    always_comb
    begin
        sd           = sb_reg[QW-1];
        st_keep_next = sd.keep;
        t0           = 19'sd0;
        t1           = 19'sd65536;
        r            = 19'sd0;
        qm           = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (sd.ef[i].zero)
            begin
                if (sd.ef[i].qneg)
                    st_keep_next = 1'b0;
            end
            else
            begin
                qm = sd.ef[i].sat ? {QW{1'b1}} : quo[i];
                r  = (sd.ef[i].qneg ^ sd.ef[i].pneg) ? -$signed({2'b00, qm})
                                                     : $signed({2'b00, qm});
                if (sd.ef[i].pneg)
                begin
                    if (r > t1)
                        st_keep_next = 1'b0;
                    else if (r > t0)
                        t0 = r;
                end
                else
                begin
                    if (r < t0)
                        st_keep_next = 1'b0;
                    else if (r < t1)
                        t1 = r;
                end
            end
        end
        st_t0_next = t0[QW-1:0];
        st_t1_next = t1[QW-1:0];
    end

    // interpolation multiply stage
    logic                 sm_valid_reg, sm_keep_reg;
    logic signed [CW-1:0] sm_x0_reg, sm_y0_reg;
    logic signed [42:0]   sm_p0x_reg, sm_p0y_reg, sm_p1x_reg, sm_p1y_reg;
    logic signed [42:0]   sm_p0x_next, sm_p0y_next, sm_p1x_next, sm_p1y_next;
    logic                 sm_keep_next;

    always_comb
    begin
        sm_p0x_next  = $signed({1'b0, st_t0_reg}) * st_dx_reg;
        sm_p0y_next  = $signed({1'b0, st_t0_reg}) * st_dy_reg;
        sm_p1x_next  = $signed({1'b0, st_t1_reg}) * st_dx_reg;
        sm_p1y_next  = $signed({1'b0, st_t1_reg}) * st_dy_reg;
        sm_keep_next = st_keep_reg && ({1'b0, st_t1_reg} > ({1'b0, st_t0_reg} + 18'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            sm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            st_valid_reg <= dv_reg[QW-1];
            sm_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_keep_reg <= st_keep_next;
            st_t0_reg   <= st_t0_next;
            st_t1_reg   <= st_t1_next;
            st_x0_reg   <= sd.x0;
            st_y0_reg   <= sd.y0;
            st_dx_reg   <= sd.dx;
            st_dy_reg   <= sd.dy;
            sm_keep_reg <= sm_keep_next;
            sm_x0_reg   <= st_x0_reg;
            sm_y0_reg   <= st_y0_reg;
            sm_p0x_reg  <= sm_p0x_next;
            sm_p0y_reg  <= sm_p0y_next;
            sm_p1x_reg  <= sm_p1x_next;
            sm_p1y_reg  <= sm_p1y_next;
        end
    end

    // final rounding, clamp, output register and skid
    logic          res_valid;
    logic [51:0]   res_data;
    logic          out_valid_reg;
    logic [51:0]   out_data_reg, skid_data_reg;

    always_comb
    begin
        res_valid = en && sm_valid_reg && sm_keep_reg;
        res_data  = {lerp(sm_y0_reg, sm_p1y_reg, OW'(LIM_Y)),
                     lerp(sm_x0_reg, sm_p1x_reg, OW'(LIM_X)),
                     lerp(sm_y0_reg, sm_p0y_reg, OW'(LIM_Y)),
                     lerp(sm_x0_reg, sm_p0x_reg, OW'(LIM_X))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        else if (res_valid)
            skid_data_reg <= res_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

endmodule

FILE: rtl/core/scpc_checker.sv
// ----------------------------------------------------------------------------
// scpc_checker
// Port-level checks of the segment cull, project and clip block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scpc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import scpc_pkg::*;

    `SCPC_ASSERT(a_full_only_with_output, !s_tready |-> m_tvalid, "input held without output word")
    `SCPC_ASSERT(a_stall_cause, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "input dropped without stall")
    `SCPC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output word lost in stall")
    `SCPC_ASSERT(a_range, m_tvalid |-> (m_tdata[12:0] <= LIM_X) && (m_tdata[25:13] <= LIM_Y) && (m_tdata[38:26] <= LIM_X) && (m_tdata[51:39] <= LIM_Y), "coordinate beyond panel")

endmodule

bind segment_cull_project_clip scpc_checker u_scpc_checker (.*);
